>>> hdl/sppd_pkg.sv
// Shared types and constants for the particle slot pool.
// Used by sppd_ctrl and slot_pool_lifetime_decay; no dependencies.
`default_nettype none

package sppd_pkg;

  // pool sizing and fixed field widths
  localparam int SLOTS_DEF = 64;
  localparam int SLOT_W    = 6;
  localparam int LIFE_W    = 16;
  localparam int PAY_W     = 80;  // x, y, size, color

  localparam logic [LIFE_W-1:0] LIFE_FULL   = 16'h8000;  // 1.0 in Q1.15
  localparam logic [15:0]       DECAY_RESET = 16'd256;   // 1.0 in Q8.8

  // register byte addresses
  localparam logic [1:0] REG_DECAY = 2'd0;

  // item opcodes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_DRAW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_DRAW
  } state_t;

  // write strobes from the sequencer to the entry memories
  typedef struct packed {
    logic life_we;
    logic pay_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> hdl/sppd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sppd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/sppd_ctrl.sv
// Sequencer for the slot pool: walks the entry memories for add, tick and draw.
// Depends on sppd_pkg.
`default_nettype none

module sppd_ctrl #(
  parameter int SLOTS = sppd_pkg::SLOTS_DEF,
  localparam int AW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command side
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    mode,
  input  wire logic signed [15:0]            pos_x,
  input  wire logic signed [15:0]            pos_y,
  input  wire logic [15:0]                   size,
  input  wire logic [31:0]                   color,
  input  wire logic [15:0]                   delta_time,
  input  wire logic [15:0]                   decay_rate,
  // memory side
  output logic [AW-1:0]                      raddr,
  output logic [AW-1:0]                      waddr,
  output logic [sppd_pkg::LIFE_W-1:0]        life_wdata,
  output logic [sppd_pkg::PAY_W-1:0]         pay_wdata,
  output sppd_pkg::mem_ctl_t                 mem,
  input  wire logic [sppd_pkg::LIFE_W-1:0]   life_rdata,
  input  wire logic [sppd_pkg::PAY_W-1:0]    pay_rdata,
  // results
  output logic                               result_valid,
  output logic [sppd_pkg::SLOT_W-1:0]        slot,
  output logic                               overwrote,
  output logic signed [15:0]                 out_x,
  output logic signed [15:0]                 out_y,
  output logic [15:0]                        out_size,
  output logic [31:0]                        out_color,
  output logic                               last
);

  localparam int SW = sppd_pkg::SLOT_W;
  localparam int PW = sppd_pkg::PAY_W;
  localparam int LW = sppd_pkg::LIFE_W;

  sppd_pkg::state_t state, state_next;

  logic [CW-1:0]  n;          // reads issued in this scan
  logic [AW-1:0]  addr;       // next read address
  logic           rd_vld;     // read data on the memory outputs this cycle
  logic [AW-1:0]  rd_slot;    // slot of that read data
  logic [AW-1:0]  search_start;
  logic [31:0]    prod;       // decay_rate * delta_time, Q16.16
  logic [PW-1:0]  in_pay;     // captured add payload
  logic           pend_vld;   // draw entry held back for the last marker
  logic [AW-1:0]  pend_slot;
  logic [PW-1:0]  pend_pay;

  logic           accept;
  logic           issue;
  logic           scan_end;
  logic           life_zero;
  logic           loss_big;
  logic [LW-1:0]  loss_lo;
  logic [LW-1:0]  life_dec;
  logic           ss_ok;
  logic [AW-1:0]  addr_inc;
  logic           emit;
  logic [AW-1:0]  e_slot;
  logic           e_ovw;
  logic [PW-1:0]  e_pay;
  logic           e_last;
  logic           pend_load;
  logic           ss_load;

  assign busy   = (state != sppd_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign raddr  = addr;

  // scan bookkeeping
  assign issue    = busy && (n != CW'(SLOTS));
  assign scan_end = (n == CW'(SLOTS)) && !rd_vld;
  assign addr_inc = (addr == AW'(SLOTS - 1)) ? '0 : addr + AW'(1);
  assign ss_ok    = (CW'(search_start) < CW'(SLOTS));

  // saturating decay: loss is the product shifted right by one
  assign life_zero = (life_rdata == '0);
  assign loss_big  = |prod[31:17];
  assign loss_lo   = prod[16:1];
  assign life_dec  = (loss_big || (loss_lo >= life_rdata)) ? '0 : life_rdata - loss_lo;

  // next state, memory writes and result selection
  always_comb begin
    state_next  = state;
    mem         = '0;
    waddr       = rd_slot;
    life_wdata  = life_dec;
    pay_wdata   = in_pay;
    emit        = 1'b0;
    e_slot      = rd_slot;
    e_ovw       = 1'b0;
    e_pay       = '0;
    e_last      = 1'b0;
    pend_load   = 1'b0;
    ss_load     = 1'b0;
    unique case (state)
      sppd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (mode)
            sppd_pkg::MODE_ADD:  state_next = sppd_pkg::ST_ADD;
            sppd_pkg::MODE_TICK: state_next = sppd_pkg::ST_TICK;
            sppd_pkg::MODE_DRAW: state_next = sppd_pkg::ST_DRAW;
            default:             state_next = sppd_pkg::ST_IDLE;
          endcase
        end
      end
      sppd_pkg::ST_ADD: begin
        if (rd_vld && life_zero) begin
          // first dead entry from the start slot
          mem.life_we = 1'b1;
          mem.pay_we  = 1'b1;
          life_wdata  = sppd_pkg::LIFE_FULL;
          emit        = 1'b1;
          e_last      = 1'b1;
          ss_load     = 1'b1;
          state_next  = sppd_pkg::ST_IDLE;
        end else if (scan_end) begin
          // pool full: reuse slot 0
          mem.life_we = 1'b1;
          mem.pay_we  = 1'b1;
          waddr       = '0;
          life_wdata  = sppd_pkg::LIFE_FULL;
          emit        = 1'b1;
          e_slot      = '0;
          e_ovw       = 1'b1;
          e_last      = 1'b1;
          state_next  = sppd_pkg::ST_IDLE;
        end
      end
      sppd_pkg::ST_TICK: begin
        if (rd_vld) begin
          mem.life_we = 1'b1;
        end
        if (scan_end) begin
          state_next = sppd_pkg::ST_IDLE;
        end
      end
      sppd_pkg::ST_DRAW: begin
        // each live entry waits in pend until the next one shows up
        if (rd_vld && !life_zero) begin
          pend_load = 1'b1;
          if (pend_vld) begin
            emit   = 1'b1;
            e_slot = pend_slot;
            e_pay  = pend_pay;
          end
        end
        if (scan_end) begin
          if (pend_vld) begin
            emit   = 1'b1;
            e_slot = pend_slot;
            e_pay  = pend_pay;
            e_last = 1'b1;
          end
          state_next = sppd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sppd_pkg::ST_IDLE;
      n            <= '0;
      addr         <= '0;
      rd_vld       <= 1'b0;
      search_start <= '0;
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rd_vld       <= issue;
      result_valid <= emit;
      if (accept) begin
        n        <= '0;
        addr     <= (mode == sppd_pkg::MODE_ADD && ss_ok) ? search_start : '0;
        pend_vld <= 1'b0;
      end else begin
        if (issue) begin
          n    <= n + CW'(1);
          addr <= addr_inc;
        end
        if (pend_load) begin
          pend_vld <= 1'b1;
        end
      end
      if (ss_load) begin
        search_start <= rd_slot;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_slot <= addr;
    if (accept) begin
      prod   <= {16'b0, decay_rate} * {16'b0, delta_time};
      in_pay <= {pos_x, pos_y, size, color};
    end
    if (pend_load) begin
      pend_slot <= rd_slot;
      pend_pay  <= pay_rdata;
    end
    if (emit) begin
      slot      <= SW'(e_slot);
      overwrote <= e_ovw;
      {out_x, out_y, out_size, out_color} <= e_pay;
      last      <= e_last;
    end
  end

  // checks
  a_ovw_slot0: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overwrote) |-> (slot == '0 && last))
    else $error("overwrite result not on slot 0 or not last");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == sppd_pkg::ST_IDLE) |-> (!mem.life_we && !mem.pay_we))
    else $error("memory write while idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(SLOTS))
    else $error("scan issued more reads than slots");

  a_pay_with_life: assert property (@(posedge clk) disable iff (rst)
    mem.pay_we |-> (mem.life_we && life_wdata == sppd_pkg::LIFE_FULL))
    else $error("payload written without a full-life entry");

endmodule

`default_nettype wire

>>> hdl/slot_pool_lifetime_decay.sv
// Top level of the particle slot pool: register port, entry memories, valid bits.
// Depends on sppd_pkg, sppd_ram and sppd_ctrl.
//
//   channel    handshake              payload
//   ---------  ---------------------  ------------------------------------------
//   command    start / busy           mode, pos_x, pos_y, size, color, delta_time
//   result     result_valid (strobe)  slot, overwrote, out_x, out_y, out_size,
//                                     out_color, last
//   config     psel/penable/pwrite    paddr, pwdata, prdata (decay_rate at 0)
//
// Each add, tick or draw walks the life memory, one read per cycle through its single
// read port; tick and draw read every slot, add stops at its first dead slot, so the
// time it holds busy depends on how far the next-fit search runs. A draw result waits
// in a pending register for the next live entry or the scan end, then is registered.
// Reset is synchronous; per-slot valid bits make every slot read as dead at once,
// so there is no clearing pass. Results are strobed for one cycle and never held.
`default_nettype none

module slot_pool_lifetime_decay #(
  parameter int SLOTS = sppd_pkg::SLOTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             mode,
  input  wire logic signed [15:0]     pos_x,
  input  wire logic signed [15:0]     pos_y,
  input  wire logic [15:0]            size,
  input  wire logic [31:0]            color,
  input  wire logic [15:0]            delta_time,
  // results
  output logic                        result_valid,
  output logic [5:0]                  slot,
  output logic                        overwrote,
  output logic signed [15:0]          out_x,
  output logic signed [15:0]          out_y,
  output logic [15:0]                 out_size,
  output logic [31:0]                 out_color,
  output logic                        last,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [1:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW = $clog2(SLOTS);
  localparam int LW = sppd_pkg::LIFE_W;
  localparam int PW = sppd_pkg::PAY_W;

  logic [15:0]        decay_rate;
  logic [SLOTS-1:0]   valid;
  logic               valid_rd;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [LW-1:0]      life_wdata;
  logic [LW-1:0]      life_raw;
  logic [LW-1:0]      life_rdata;
  logic [PW-1:0]      pay_wdata;
  logic [PW-1:0]      pay_rdata;
  sppd_pkg::mem_ctl_t mem;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == sppd_pkg::REG_DECAY) ? {16'b0, decay_rate} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate <= sppd_pkg::DECAY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == sppd_pkg::REG_DECAY) begin
      decay_rate <= pwdata[15:0];
    end
  end

  // per-slot valid bits: an unwritten slot reads as life zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      valid_rd <= 1'b0;
    end else begin
      valid_rd <= valid[raddr];
      if (mem.life_we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign life_rdata = valid_rd ? life_raw : '0;

  // entry memories
  sppd_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_life_ram (
    .clk   (clk),
    .we    (mem.life_we),
    .waddr (waddr),
    .wdata (life_wdata),
    .raddr (raddr),
    .rdata (life_raw)
  );

  sppd_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (mem.pay_we),
    .waddr (waddr),
    .wdata (pay_wdata),
    .raddr (raddr),
    .rdata (pay_rdata)
  );

  // sequencer
  sppd_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .size         (size),
    .color        (color),
    .delta_time   (delta_time),
    .decay_rate   (decay_rate),
    .raddr        (raddr),
    .waddr        (waddr),
    .life_wdata   (life_wdata),
    .pay_wdata    (pay_wdata),
    .mem          (mem),
    .life_rdata   (life_rdata),
    .pay_rdata    (pay_rdata),
    .result_valid (result_valid),
    .slot         (slot),
    .overwrote    (overwrote),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_size     (out_size),
    .out_color    (out_color),
    .last         (last)
  );

endmodule

`default_nettype wire

>>> tb/sppd_tb_pkg.sv
// Command/result types and the pool mirror used by the slot pool testbench.
// Depends on sppd_pkg for the opcodes, sizing and life constants.
package sppd_tb_pkg;
  import sppd_pkg::*;

  localparam int POOL_SLOTS = SLOTS_DEF;
  // opcode the block ignores
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size;
    logic [31:0]        color;
    logic [15:0]        delta_time;
  } cmd_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               overwrote;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_size;
    logic [31:0]        out_color;
    logic               last;
  } res_t;

  // Mirror of the particle pool; predicts results and checks them in order
  class pool_mirror;
    logic [15:0] decay;
    logic [15:0] life [POOL_SLOTS];
    logic [15:0] xpos [POOL_SLOTS];
    logic [15:0] ypos [POOL_SLOTS];
    logic [15:0] wid  [POOL_SLOTS];
    logic [31:0] rgba [POOL_SLOTS];
    logic [5:0]  next_fit;
    res_t        pending_results [$];
    int          errors;

    function new();
      decay    = DECAY_RESET;
      next_fit = '0;
      errors   = 0;
      foreach (life[i]) begin
        life[i] = '0;
        xpos[i] = '0;
        ypos[i] = '0;
        wid[i]  = '0;
        rgba[i] = '0;
      end
    endfunction

    function void set_decay(logic [15:0] v);
      decay = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // note an accepted item and queue the results it causes
    function void apply_item(cmd_t c);
      int unsigned first, idx, n, loss;
      int          last_live;
      bit          found;
      res_t        r;
      r = '0;
      case (c.mode)
        MODE_ADD: begin
          first = (next_fit >= POOL_SLOTS) ? 0 : next_fit;
          found = 1'b0;
          idx   = 0;
          for (n = 0; n < POOL_SLOTS && !found; n++) begin
            if (life[(first + n) % POOL_SLOTS] == '0) begin
              found = 1'b1;
              idx   = (first + n) % POOL_SLOTS;
            end
          end
          // full pool: slot 0 is reused and the search point stays put
          if (found) next_fit = idx[5:0];
          life[idx]   = LIFE_FULL;
          xpos[idx]   = c.pos_x;
          ypos[idx]   = c.pos_y;
          wid[idx]    = c.size;
          rgba[idx]   = c.color;
          r.slot      = idx[5:0];
          r.overwrote = !found;
          r.last      = 1'b1;
          pending_results.push_back(r);
        end
        MODE_TICK: begin
          // Q8.8 * Q8.8 product, one right shift gives Q1.15 life units
          loss = (32'(decay) * 32'(c.delta_time)) >> 1;
          foreach (life[i]) begin
            if (life[i] != '0) begin
              if (loss >= 32'(life[i])) life[i] = '0;
              else life[i] = life[i] - loss[15:0];
            end
          end
        end
        MODE_DRAW: begin
          last_live = -1;
          foreach (life[i]) if (life[i] != '0) last_live = i;
          foreach (life[i]) begin
            if (life[i] != '0) begin
              r.slot      = i[5:0];
              r.overwrote = 1'b0;
              r.out_x     = xpos[i];
              r.out_y     = ypos[i];
              r.out_size  = wid[i];
              r.out_color = rgba[i];
              r.last      = (i == last_live);
              pending_results.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one strobed result against the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual slot %0d",
                 $time, got.slot);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("slot",      32'(want.slot),         32'(got.slot));
      cmp_field("overwrote", 32'(want.overwrote),    32'(got.overwrote));
      cmp_field("out_x",     32'(unsigned'(want.out_x)), 32'(unsigned'(got.out_x)));
      cmp_field("out_y",     32'(unsigned'(want.out_y)), 32'(unsigned'(got.out_y)));
      cmp_field("out_size",  32'(want.out_size),     32'(got.out_size));
      cmp_field("out_color", want.out_color,         got.out_color);
      cmp_field("last",      32'(want.last),         32'(got.last));
    endfunction
  endclass

endpackage

>>> tb/testbench.sv
// Top-level testbench for slot_pool_lifetime_decay: drives commands and APB writes,
// checks every strobed result against pool_mirror. Depends on sppd_pkg, sppd_tb_pkg.
module testbench;
  import sppd_pkg::*;
  import sppd_tb_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode = MODE_ADD;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [15:0]        size = '0;
  logic [31:0]        color = '0;
  logic [15:0]        delta_time = '0;
  logic               result_valid;
  logic [5:0]         slot;
  logic               overwrote;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [15:0]        out_size;
  logic [31:0]        out_color;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = REG_DECAY;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  pool_mirror book;
  res_t       seen;

  slot_pool_lifetime_decay dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .mode(mode), .pos_x(pos_x), .pos_y(pos_y),
    .size(size), .color(color), .delta_time(delta_time),
    .result_valid(result_valid), .slot(slot), .overwrote(overwrote),
    .out_x(out_x), .out_y(out_y), .out_size(out_size), .out_color(out_color),
    .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL slot_pool_lifetime_decay");
    $finish;
  end

  // result monitor: the block strobes each result for one cycle
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      seen.slot      = slot;
      seen.overwrote = overwrote;
      seen.out_x     = out_x;
      seen.out_y     = out_y;
      seen.out_size  = out_size;
      seen.out_color = out_color;
      seen.last      = last;
      book.check_result(seen);
    end
  end

  function automatic cmd_t mk_cmd(logic [1:0] m, logic [15:0] x, logic [15:0] y,
                                  logic [15:0] sz, logic [31:0] col, logic [15:0] dt);
    cmd_t c;
    c.mode       = m;
    c.pos_x      = x;
    c.pos_y      = y;
    c.size       = sz;
    c.color      = col;
    c.delta_time = dt;
    return c;
  endfunction

  // weighted random item; add_pct steers how fast the pool fills
  function automatic cmd_t rand_cmd(int unsigned add_pct);
    cmd_t        c;
    int unsigned roll, span;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) c.mode = MODE_ADD;
    else if (roll < add_pct + (100 - add_pct) / 2) c.mode = MODE_TICK;
    else if (roll < 97) c.mode = MODE_DRAW;
    else c.mode = MODE_NONE;
    c.pos_x = 16'($urandom);
    c.pos_y = 16'($urandom);
    c.size  = 16'($urandom);
    c.color = $urandom;
    span = $urandom_range(0, 9);
    if (span < 7) c.delta_time = 16'($urandom_range(0, 24));
    else if (span < 9) c.delta_time = 16'($urandom_range(0, 255));
    else c.delta_time = 16'($urandom);
    return c;
  endfunction

  // present an item at the falling edge and hold it until accepted;
  // returns at the next falling edge with start still high
  task automatic issue_item(cmd_t c);
    start      <= 1'b1;
    mode       <= c.mode;
    pos_x      <= c.pos_x;
    pos_y      <= c.pos_y;
    size       <= c.size;
    color      <= c.color;
    delta_time <= c.delta_time;
    do @(posedge clk); while (busy);
    book.apply_item(c);
    @(negedge clk);
  endtask

  // wait for every expected result, then let the block finish its walk
  task automatic drain_results();
    while (book.pending() != 0) @(posedge clk);
    repeat (POOL_SLOTS + 8) @(posedge clk);
    @(negedge clk);
  endtask

  // called at a falling edge right after an item; leaves the block idle
  task automatic quiesce();
    start <= 1'b0;
    drain_results();
  endtask

  // APB write of decay_rate, setup then access phase, called at a falling edge while idle
  task automatic write_decay(logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DECAY;
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_decay(v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [15:0] rates [6];
    int unsigned add_pct [6];
    int          counted, burst_left, gap;
    cmd_t        c;

    book = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pool, field extremes, decay corner cases
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    issue_item(mk_cmd(MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'hffff));
    issue_item(mk_cmd(MODE_NONE, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 16'hffff));
    issue_item(mk_cmd(MODE_ADD, 16'h8000, 16'h7fff, 16'h0000, 32'h00000000, 16'h0));
    issue_item(mk_cmd(MODE_ADD, 16'h7fff, 16'h8000, 16'hffff, 32'hffffffff, 16'h0));
    issue_item(mk_cmd(MODE_ADD, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                      16'h0));
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    issue_item(mk_cmd(MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    quiesce();
    // a product of one truncates to no loss
    write_decay(16'd1);
    issue_item(mk_cmd(MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'd1));
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    quiesce();
    // half a life per tick, then the first three entries die exactly
    write_decay(16'd256);
    issue_item(mk_cmd(MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'd128));
    issue_item(mk_cmd(MODE_ADD, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                      16'h0));
    issue_item(mk_cmd(MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'd128));
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    issue_item(mk_cmd(MODE_ADD, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                      16'h0));
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    quiesce();
    // maximum decay wipes the pool
    write_decay(16'hffff);
    issue_item(mk_cmd(MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'hffff));
    issue_item(mk_cmd(MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    issue_item(mk_cmd(MODE_ADD, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                      16'h0));
    quiesce();

    // random phases, one decay setting each; zero decay lets the pool overflow
    rates   = '{16'd0, 16'hffff, 16'd1, 16'd256, 16'($urandom_range(2, 65534)), 16'd128};
    add_pct = '{70, 50, 55, 50, 50, 60};
    for (int p = 0; p < 6; p++) begin
      write_decay(rates[p]);
      counted    = 0;
      burst_left = $urandom_range(1, 12);
      while (counted < 67) begin
        c = rand_cmd(add_pct[p]);
        issue_item(c);
        if (c.mode != MODE_NONE) counted++;
        burst_left--;
        if ($urandom_range(0, 39) == 0) begin
          // hold off until the pool has answered everything
          quiesce();
          burst_left = $urandom_range(1, 12);
        end else if (burst_left == 0) begin
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
          end
          burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
      end
      quiesce();
    end

    if (book.errors == 0 && book.pending() == 0) begin
      $display("PASS slot_pool_lifetime_decay");
    end else begin
      $display("FAIL slot_pool_lifetime_decay");
    end
    $finish;
  end

endmodule

>>> slot_pool_lifetime_decay.f
hdl/sppd_pkg.sv
hdl/sppd_ram.sv
hdl/sppd_ctrl.sv
hdl/slot_pool_lifetime_decay.sv
tb/sppd_tb_pkg.sv
tb/testbench.sv
